// ----- rtl/core/rrc_pkg.sv -----
// Shared types, constants and helpers for the read request coalescer.
// Used by rrc_table, rrc_seq and read_request_coalescer; no dependencies.

package rrc_pkg;

    localparam int AREA_W  = 3;
    localparam int BLOCK_W = 16;
    localparam int BYTE_W  = 16;
    localparam int END_W   = 17;
    localparam int VTYPE_W = 4;
    localparam int SIZE_W  = 3;
    localparam int SPAN_W  = 16;
    localparam int STAT_W  = 2;
    localparam int OIDX_W  = 6;

    localparam int              MAX_GROUPS_DEF = 64;
    localparam logic [SPAN_W-1:0] MAX_SPAN_RESET = 16'd200;

    localparam logic [AREA_W-1:0] AREA_UNDEF   = 3'd0;
    localparam logic [AREA_W-1:0] AREA_COUNTER = 3'd1;
    localparam logic [AREA_W-1:0] AREA_TIMER   = 3'd2;

    typedef enum logic [STAT_W-1:0] {
        STAT_PLACED = 2'd0,
        STAT_UNDEF  = 2'd1,
        STAT_FULL   = 2'd2
    } status_t;

    typedef struct packed {
        logic [AREA_W-1:0]  area;
        logic [BLOCK_W-1:0] block;
        logic [BYTE_W-1:0]  first_byte;
        logic [END_W-1:0]   end_byte;
    } entry_t;

    function automatic logic [SIZE_W-1:0] item_size(
        input logic [AREA_W-1:0]  area,
        input logic [VTYPE_W-1:0] vtype
    );
        logic [SIZE_W-1:0] sz;
        sz = 3'd0;
        if (area == AREA_COUNTER || area == AREA_TIMER) begin
            sz = 3'd2;
        end else if (vtype >= 4'd1 && vtype <= 4'd2) begin
            sz = 3'd1;
        end else if (vtype >= 4'd3 && vtype <= 4'd6) begin
            sz = 3'd2;
        end else if (vtype >= 4'd7 && vtype <= 4'd11) begin
            sz = 3'd4;
        end
        return sz;
    endfunction

endpackage

// ----- rtl/core/rrc_table.sv -----
// Group table storage: one write port and one registered read port.
// Depends on rrc_pkg for the entry layout.

module rrc_table
    import rrc_pkg::*;
#(
    parameter int MAX_GROUPS = MAX_GROUPS_DEF,
    parameter int IDX_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1
) (
    input  logic             aclk,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data
);

    entry_t mem [MAX_GROUPS];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/rrc_seq.sv -----
// Sequencer with the shared merge/compare unit for the coalescer.
// Depends on rrc_pkg; drives rrc_table through its read and write ports.

module rrc_seq
    import rrc_pkg::*;
#(
    parameter int MAX_GROUPS = MAX_GROUPS_DEF,
    parameter int IDX_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1,
    parameter int CNT_W      = $clog2(MAX_GROUPS + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [SPAN_W-1:0]   max_span,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_first,
    input  logic [AREA_W-1:0]   in_area,
    input  logic [BLOCK_W-1:0]  in_block,
    input  logic [BYTE_W-1:0]   in_offset,
    input  logic [VTYPE_W-1:0]  in_vtype,
    output logic                out_valid,
    input  logic                out_ready,
    output status_t             out_status,
    output logic [OIDX_W-1:0]   out_index,
    output logic                out_new,
    output logic [BYTE_W-1:0]   out_start,
    output logic [END_W-1:0]    out_length,
    output logic [IDX_W-1:0]    rd_addr,
    input  entry_t              rd_data,
    output logic                wr_en,
    output logic [IDX_W-1:0]    wr_addr,
    output entry_t              wr_data
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_APPEND = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic cmp_vld_reg, cmp_vld_next;

    logic [AREA_W-1:0]  area_reg, area_next;
    logic [BLOCK_W-1:0] block_reg, block_next;
    logic [BYTE_W-1:0]  offset_reg, offset_next;
    logic [END_W-1:0]   end_reg, end_next;

    status_t            res_status_reg, res_status_next;
    logic [IDX_W-1:0]   res_idx_reg, res_idx_next;
    logic               res_new_reg, res_new_next;
    logic [BYTE_W-1:0]  res_start_reg, res_start_next;
    logic [END_W-1:0]   res_len_reg, res_len_next;

    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [OIDX_W-1:0]  m_index_reg, m_index_next;
    logic               m_new_reg, m_new_next;
    logic [BYTE_W-1:0]  m_start_reg, m_start_next;
    logic [END_W-1:0]   m_len_reg, m_len_next;

    logic [CNT_W-1:0]   count_eff;
    logic               issue;
    logic [BYTE_W-1:0]  mrg_start;
    logic [END_W-1:0]   mrg_end;
    logic [END_W-1:0]   mrg_span;
    logic               match;
    logic [IDX_W+OIDX_W-1:0] idx_wide;

    assign in_ready = (state_reg == ST_IDLE);
    assign rd_addr  = scan_idx_reg[IDX_W-1:0];
    assign issue    = (scan_idx_reg < count_reg);
    assign count_eff = in_first ? '0 : count_reg;

    // shared merge and compare unit
    always_comb begin
        mrg_start = (offset_reg < rd_data.first_byte) ? offset_reg : rd_data.first_byte;
        mrg_end   = (end_reg > rd_data.end_byte) ? end_reg : rd_data.end_byte;
        mrg_span  = mrg_end - {1'b0, mrg_start};
        match     = cmp_vld_reg && (rd_data.area == area_reg)
                    && (rd_data.block == block_reg)
                    && (mrg_span < {1'b0, max_span});
    end

    assign idx_wide = {{OIDX_W{1'b0}}, res_idx_reg};

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_vld_next    = 1'b0;
        area_next       = area_reg;
        block_next      = block_reg;
        offset_next     = offset_reg;
        end_next        = end_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_new_next    = res_new_reg;
        res_start_next  = res_start_reg;
        res_len_next    = res_len_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_index_next    = m_index_reg;
        m_new_next      = m_new_reg;
        m_start_next    = m_start_reg;
        m_len_next      = m_len_reg;
        wr_en           = 1'b0;
        wr_addr         = cmp_idx_reg;
        wr_data         = '{area: area_reg, block: block_reg,
                            first_byte: mrg_start, end_byte: mrg_end};

        if (m_valid_reg && out_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    area_next     = in_area;
                    block_next    = in_block;
                    offset_next   = in_offset;
                    end_next      = {1'b0, in_offset}
                                    + {{(END_W-SIZE_W){1'b0}}, item_size(in_area, in_vtype)};
                    scan_idx_next = '0;
                    count_next    = count_eff;
                    if (in_area == AREA_UNDEF) begin
                        count_next      = '0;
                        res_status_next = STAT_UNDEF;
                        res_idx_next    = '0;
                        res_new_next    = 1'b0;
                        res_start_next  = '0;
                        res_len_next    = '0;
                        state_next      = ST_DONE;
                    end else if (in_area == AREA_COUNTER || in_area == AREA_TIMER
                                 || count_eff == '0) begin
                        state_next = ST_APPEND;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (match) begin
                    wr_en           = 1'b1;
                    res_status_next = STAT_PLACED;
                    res_idx_next    = cmp_idx_reg;
                    res_new_next    = 1'b0;
                    res_start_next  = mrg_start;
                    res_len_next    = mrg_span;
                    state_next      = ST_DONE;
                end else if (!issue) begin
                    state_next = ST_APPEND;
                end else begin
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            ST_APPEND: begin
                if (count_reg == CNT_W'(MAX_GROUPS)) begin
                    res_status_next = STAT_FULL;
                    res_idx_next    = '0;
                    res_new_next    = 1'b0;
                    res_start_next  = '0;
                    res_len_next    = '0;
                end else begin
                    wr_en           = 1'b1;
                    wr_addr         = count_reg[IDX_W-1:0];
                    wr_data         = '{area: area_reg, block: block_reg,
                                        first_byte: offset_reg, end_byte: end_reg};
                    count_next      = count_reg + 1'b1;
                    res_status_next = STAT_PLACED;
                    res_idx_next    = count_reg[IDX_W-1:0];
                    res_new_next    = 1'b1;
                    res_start_next  = offset_reg;
                    res_len_next    = end_reg - {1'b0, offset_reg};
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || out_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_index_next  = idx_wide[OIDX_W-1:0];
                    m_new_next    = res_new_reg;
                    m_start_next  = res_start_reg;
                    m_len_next    = res_len_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        area_reg       <= area_next;
        block_reg      <= block_next;
        offset_reg     <= offset_next;
        end_reg        <= end_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_new_reg    <= res_new_next;
        res_start_reg  <= res_start_next;
        res_len_reg    <= res_len_next;
        m_status_reg   <= m_status_next;
        m_index_reg    <= m_index_next;
        m_new_reg      <= m_new_next;
        m_start_reg    <= m_start_next;
        m_len_reg      <= m_len_next;
    end

    assign out_valid  = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_index  = m_index_reg;
    assign out_new    = m_new_reg;
    assign out_start  = m_start_reg;
    assign out_length = m_len_reg;

endmodule

// ----- rtl/core/read_request_coalescer.sv -----
// Top level of the read request coalescer: stream ports, max_span register.
// Depends on rrc_pkg, rrc_table and rrc_seq.

// Each accepted descriptor is placed into a table of up to MAX_GROUPS read
// groups: it joins the first group with equal area and block whose merged
// byte span stays below max_span, or opens a new group; counters and timers
// always open their own group. A full table gives a full status instead of a
// new group, and an undefined area gives an undefined status and empties the
// table. One result item follows every input item. The scan covers the
// groups in use after any first-of-list clear and stops at the first match;
// no scan runs for counters, timers or an empty table. It reads one table
// entry per cycle through the single read port of the group memory and runs
// it through one shared merge/compare unit. s_tready is high only while the
// sequencer is idle, so the next item is accepted in the cycle after the
// result is registered at the earliest. A finished result may wait in the
// output register meanwhile; the sequencer holds in its last step until
// that register is free. No clearing pass is needed after reset.

module read_request_coalescer
    import rrc_pkg::*;
#(
    parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // max_span
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // area_code, block_number, byte_offset, value_type
    input  logic [0:0]  s_tuser,       // first_of_list
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,       // group_index, new_group, group_start, group_length
    output logic [1:0]  m_tuser        // status
);

    localparam int IDX_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CNT_W = $clog2(MAX_GROUPS + 1);

    logic [SPAN_W-1:0] max_span_reg;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    status_t           out_status;
    logic [OIDX_W-1:0] out_index;
    logic              out_new;
    logic [BYTE_W-1:0] out_start;
    logic [END_W-1:0]  out_length;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_span_reg <= MAX_SPAN_RESET;
        end else if (cfg_wr_en) begin
            max_span_reg <= cfg_wr_data;
        end
    end

    rrc_table #(
        .MAX_GROUPS (MAX_GROUPS),
        .IDX_W      (IDX_W)
    ) u_table (
        .aclk    (aclk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    rrc_seq #(
        .MAX_GROUPS (MAX_GROUPS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .max_span   (max_span_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_first   (s_tuser[0]),
        .in_area    (s_tdata[2:0]),
        .in_block   (s_tdata[18:3]),
        .in_offset  (s_tdata[34:19]),
        .in_vtype   (s_tdata[38:35]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_index  (out_index),
        .out_new    (out_new),
        .out_start  (out_start),
        .out_length (out_length),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    assign m_tuser = out_status;
    assign m_tdata = {out_length, out_start, out_new, out_index};

endmodule

// ----- sim/read_request_coalescer_tb.sv -----
// Self-checking testbench for read_request_coalescer: drives descriptor items,
// predicts each group placement and checks every result item field by field.
// Depends on rrc_pkg and the read_request_coalescer RTL.
`timescale 1ns / 1ps

module read_request_coalescer_tb;
    import rrc_pkg::*;

    typedef struct packed {
        logic                first;
        logic [AREA_W-1:0]   area;
        logic [BLOCK_W-1:0]  block;
        logic [BYTE_W-1:0]   offset;
        logic [VTYPE_W-1:0]  vtype;
    } desc_t;

    typedef struct packed {
        status_t             status;
        logic [OIDX_W-1:0]   idx;
        logic                fresh;
        logic [BYTE_W-1:0]   start;
        logic [END_W-1:0]    len;
    } placement_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    desc_t      descriptor_queue[$];
    placement_t placement_queue[$];

    logic [AREA_W-1:0]  tab_area [MAX_GROUPS_DEF];
    logic [BLOCK_W-1:0] tab_block[MAX_GROUPS_DEF];
    logic [END_W-1:0]   tab_lo   [MAX_GROUPS_DEF];
    logic [END_W-1:0]   tab_hi   [MAX_GROUPS_DEF];
    int                 tab_used = 0;
    logic [SPAN_W-1:0]  span_limit = MAX_SPAN_RESET;

    bit idle_en = 1'b1;
    int mismatches = 0;
    int src_gap = 0;
    int sink_gap = 0;
    int hold_left = 0;
    int results_taken = 0;

    read_request_coalescer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic placement_t place_descriptor(input desc_t d);
        placement_t        r;
        logic [SIZE_W-1:0] sz;
        logic [END_W-1:0]  item_hi;
        logic [END_W-1:0]  lo;
        logic [END_W-1:0]  hi;
        int                j;
        bit                joined;
        r.status = STAT_PLACED;
        r.idx    = '0;
        r.fresh  = 1'b0;
        r.start  = '0;
        r.len    = '0;
        joined   = 1'b0;
        if (d.first) tab_used = 0;
        if (d.area == AREA_UNDEF) begin
            tab_used = 0;
            r.status = STAT_UNDEF;
            return r;
        end
        if (d.area == AREA_COUNTER || d.area == AREA_TIMER) begin
            sz = 3'd2;
        end else begin
            case (d.vtype)
                4'd1, 4'd2:                      sz = 3'd1;
                4'd3, 4'd4, 4'd5, 4'd6:          sz = 3'd2;
                4'd7, 4'd8, 4'd9, 4'd10, 4'd11:  sz = 3'd4;
                default:                         sz = 3'd0;
            endcase
        end
        item_hi = {1'b0, d.offset} + sz;
        if (d.area != AREA_COUNTER && d.area != AREA_TIMER) begin
            for (j = 0; j < tab_used && !joined; j++) begin
                if (tab_area[j] == d.area && tab_block[j] == d.block) begin
                    lo = ({1'b0, d.offset} < tab_lo[j]) ? {1'b0, d.offset} : tab_lo[j];
                    hi = (item_hi > tab_hi[j]) ? item_hi : tab_hi[j];
                    if (hi - lo < {1'b0, span_limit}) begin
                        tab_lo[j] = lo;
                        tab_hi[j] = hi;
                        r.idx     = OIDX_W'(j);
                        r.start   = lo[BYTE_W-1:0];
                        r.len     = hi - lo;
                        joined    = 1'b1;
                    end
                end
            end
        end
        if (!joined) begin
            if (tab_used >= MAX_GROUPS_DEF) begin
                r.status = STAT_FULL;
            end else begin
                tab_area[tab_used]  = d.area;
                tab_block[tab_used] = d.block;
                tab_lo[tab_used]    = {1'b0, d.offset};
                tab_hi[tab_used]    = item_hi;
                r.idx   = OIDX_W'(tab_used);
                r.fresh = 1'b1;
                r.start = d.offset;
                r.len   = item_hi - {1'b0, d.offset};
                tab_used++;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : source
        bit    go;
        desc_t d;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            go = 1'b0;
            if (src_gap > 0) begin
                src_gap--;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                src_gap = $urandom_range(1, 7);
            end
            if (src_gap == 0 && descriptor_queue.size() != 0) begin
                d  = descriptor_queue.pop_front();
                go = 1'b1;
                s_tdata <= {1'b0, d.vtype, d.offset, d.block, d.area};
                s_tuser <= d.first;
            end
            s_tvalid <= go;
        end
    end

    always @(posedge aclk) begin : sink
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) results_taken++;
            if (hold_left > 0) begin
                hold_left--;
            end else if (m_tvalid && m_tready && results_taken == 150) begin
                hold_left = 400;
            end else if (sink_gap > 0) begin
                sink_gap--;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(1, 7);
            end
            m_tready <= (hold_left == 0 && sink_gap == 0);
        end
    end

    always @(posedge aclk) begin : monitor
        placement_t exp_r;
        desc_t      d;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (placement_queue.size() == 0) begin
                    $error("result item with no placement pending");
                    mismatches++;
                end else begin
                    exp_r = placement_queue.pop_front();
                    check_field("status", int'(exp_r.status), int'(m_tuser));
                    check_field("group_index", int'(exp_r.idx), int'(m_tdata[5:0]));
                    check_field("new_group", int'(exp_r.fresh), int'(m_tdata[6]));
                    check_field("group_start", int'(exp_r.start), int'(m_tdata[22:7]));
                    check_field("group_length", int'(exp_r.len), int'(m_tdata[39:23]));
                end
            end
            if (s_tvalid && s_tready) begin
                d.first  = s_tuser[0];
                d.area   = s_tdata[2:0];
                d.block  = s_tdata[18:3];
                d.offset = s_tdata[34:19];
                d.vtype  = s_tdata[38:35];
                placement_queue.push_back(place_descriptor(d));
            end
        end
    end

    task automatic push_desc(input logic first, input int area, input int block,
                             input int offset, input int vtype);
        desc_t d;
        d.first  = first;
        d.area   = AREA_W'(area);
        d.block  = BLOCK_W'(block);
        d.offset = BYTE_W'(offset);
        d.vtype  = VTYPE_W'(vtype);
        descriptor_queue.push_back(d);
    endtask

    task automatic add_random(input int target);
        int                 added;
        int                 n;
        int                 spread;
        int                 r;
        int                 i;
        bit                 fill;
        logic [BYTE_W-1:0]  base;
        logic [BLOCK_W-1:0] blk_a;
        logic [BLOCK_W-1:0] blk_b;
        logic [AREA_W-1:0]  area_a;
        logic [AREA_W-1:0]  area_b;
        desc_t              d;
        added = 0;
        while (added < target) begin
            fill = ($urandom_range(0, 7) == 0);
            n = fill ? 70 : $urandom_range(1, 40);
            case ($urandom_range(0, 3))
                0:       spread = 8;
                1:       spread = 64;
                2:       spread = 300;
                default: spread = 4000;
            endcase
            base   = BYTE_W'($urandom);
            blk_a  = BLOCK_W'($urandom);
            blk_b  = BLOCK_W'($urandom_range(0, 3));
            area_a = AREA_W'($urandom_range(3, 7));
            area_b = AREA_W'($urandom_range(3, 7));
            for (i = 0; i < n && added < target; i++) begin
                if (fill) begin
                    d.first  = (i == 0);
                    d.area   = AREA_W'($urandom_range(3, 7));
                    d.block  = blk_a + BLOCK_W'(i);
                    d.offset = BYTE_W'($urandom);
                    d.vtype  = VTYPE_W'($urandom);
                end else begin
                    d.first = (i == 0) || ($urandom_range(0, 49) == 0);
                    r = $urandom_range(0, 99);
                    if (r < 3)       d.area = AREA_UNDEF;
                    else if (r < 8)  d.area = AREA_COUNTER;
                    else if (r < 13) d.area = AREA_TIMER;
                    else             d.area = r[0] ? area_a : area_b;
                    if ($urandom_range(0, 9) == 0) d.block = BLOCK_W'($urandom);
                    else d.block = $urandom_range(0, 1) ? blk_a : blk_b;
                    if ($urandom_range(0, 15) == 0) d.offset = BYTE_W'($urandom);
                    else d.offset = base + BYTE_W'($urandom_range(0, spread));
                    d.vtype = VTYPE_W'($urandom_range(0, 15));
                end
                descriptor_queue.push_back(d);
                added++;
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (descriptor_queue.size() != 0 || s_tvalid || placement_queue.size() != 0);
    endtask

    task automatic write_span(input logic [SPAN_W-1:0] v);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        span_limit = v;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        push_desc(1, 3, 0, 100, 1);
        push_desc(0, 3, 0, 50, 7);
        push_desc(0, 3, 0, 300, 3);
        push_desc(0, 3, 0, 249, 0);
        push_desc(0, 3, 0, 250, 2);
        push_desc(0, 3, 1, 250, 4);
        push_desc(0, 4, 0, 250, 5);
        push_desc(0, 1, 0, 250, 6);
        push_desc(0, 2, 0, 250, 11);
        push_desc(0, 7, 65535, 65535, 11);
        push_desc(0, 7, 65535, 65534, 8);
        push_desc(0, 5, 7, 0, 12);
        push_desc(0, 5, 7, 0, 15);
        push_desc(0, 6, 3, 10, 9);
        push_desc(0, 0, 65535, 65535, 15);
        push_desc(0, 3, 0, 100, 10);
        push_desc(1, 3, 0, 100, 1);
        push_desc(1, 0, 0, 0, 0);
        push_desc(0, 2, 0, 65535, 0);
        push_desc(0, 1, 12, 65534, 13);

        write_span(16'd1);
        add_random(180);
        wait_idle();
        add_random(178);

        write_span(16'hFFFF);
        add_random(358);

        write_span(16'd16);
        add_random(358);

        write_span(16'd200);
        idle_en = 1'b0;
        add_random(358);

        wait_idle();
        repeat (80) @(posedge aclk);
        if (placement_queue.size() != 0) begin
            $error("%0d placements never arrived", placement_queue.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("read_request_coalescer regression: pass");
        end else begin
            $display("read_request_coalescer regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("read_request_coalescer regression: fail");
        $finish;
    end

endmodule
